FILE: hdl/addressable_led_bit_serializer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the addressable LED bit serializer
// Each check is compiled in simulation and left empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_BIT_SERIALIZER_DEFINES_SVH
`define ADDRESSABLE_LED_BIT_SERIALIZER_DEFINES_SVH

`ifndef SYNTH
// Checked only while out of reset
`define ALBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, reset included
`define ALBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ALBS_ASSERT(lbl, prop, msg)
`define ALBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/albs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// albs_pkg
// Types and constants shared by the LED bit serializer and its colour store.
// ---------------------------------------------------------------------------
package albs_pkg;

    localparam int LED_COUNT = 64;
    localparam int LED_PTR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int ACT_W      = 2;
    localparam int IDX_W      = 6;
    localparam int CMP_W      = 10;
    localparam int SLOT_W     = 8;
    localparam int BIT_PTR_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [BIT_PTR_W-1:0] TOP_BIT = 5'd23;

    // Item actions
    localparam logic [ACT_W-1:0] ACT_WRITE_ONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE_ALL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK      = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_COMPARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_COMPARE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SLOTS  = 2'd2;

    localparam logic [CMP_W-1:0]  HIGH_COMPARE_RST = 10'd56;
    localparam logic [CMP_W-1:0]  LOW_COMPARE_RST  = 10'd32;
    localparam logic [SLOT_W-1:0] RESET_SLOTS_RST  = 8'd100;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  led_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } albs_in_t;

    typedef struct packed {
        logic [CMP_W-1:0] compare_value;
        logic             last_slot;
    } albs_out_t;

    // Request from the sequencer to the colour store
    typedef struct packed {
        logic                 wr_one;
        logic                 wr_all;
        logic                 rd_en;
        logic [LED_PTR_W-1:0] addr;
        logic [COLOR_W-1:0]   wr_data;
    } albs_store_req_t;

endpackage

FILE: hdl/albs_color_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// albs_color_store
// One colour per LED in a synchronous memory. A fill colour plus a valid bit
// per entry stand in for reset and for a write to every LED at once.
// ---------------------------------------------------------------------------
module albs_color_store
    import albs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  albs_store_req_t    req,
    output logic [COLOR_W-1:0] rd_word
);

    logic [COLOR_W-1:0]   color_mem [LED_COUNT];
    logic [COLOR_W-1:0]   rd_data_reg;
    logic                 rd_valid_reg;
    logic [LED_COUNT-1:0] valid_reg;
    logic [LED_COUNT-1:0] valid_next;
    logic [COLOR_W-1:0]   fill_reg;
    logic [COLOR_W-1:0]   fill_next;

    always_ff @(posedge aclk) begin
        if (req.wr_one) begin
            color_mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg  <= color_mem[req.addr];
            rd_valid_reg <= valid_reg[req.addr];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        fill_next  = fill_reg;
        if (req.wr_all) begin
            // drop every entry back to the new fill colour
            valid_next = '0;
            fill_next  = req.wr_data;
        end else if (req.wr_one) begin
            valid_next[req.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
        end
    end

    // Fill colour cannot change while a read is outstanding
    assign rd_word = rd_valid_reg ? rd_data_reg : fill_reg;

endmodule

FILE: hdl/addressable_led_bit_serializer.sv
`timescale 1ns / 1ps
// Addressable LED bit serializer. Items write one LED colour, write every LED,
// start a frame or mark one bit slot. During a frame each slot transfer gives
// one compare value: 24 bits per LED in green, red, blue order, MSB first,
// then the configured number of zero reset slots, the final slot flagged.
// A slot inside the LED data passes through ST_READ, since the colour store
// read is registered before the bit is chosen; reset slots, colour writes,
// starts and ignored items are handled in ST_IDLE. The result sits in an
// output register, so a new item is taken in the cycle its predecessor's
// result is transferred. Writes and starts during a frame are dropped.
// ---------------------------------------------------------------------------
// addressable_led_bit_serializer
// Frame sequencer, configuration registers and result register.
// ---------------------------------------------------------------------------
`include "addressable_led_bit_serializer_defines.svh"

module addressable_led_bit_serializer
    import albs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  albs_in_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output albs_out_t             m_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                 state_reg, state_next;
    logic                 sending_reg, sending_next;
    logic                 in_tail_reg, in_tail_next;
    logic [LED_PTR_W-1:0] led_ptr_reg, led_ptr_next;
    logic [BIT_PTR_W-1:0] bit_ptr_reg, bit_ptr_next;
    logic [SLOT_W-1:0]    tail_reg, tail_next;

    logic [CMP_W-1:0]     high_cmp_reg;
    logic [CMP_W-1:0]     low_cmp_reg;
    logic [SLOT_W-1:0]    reset_slots_reg;

    logic                 m_valid_reg, m_valid_next;
    albs_out_t            m_data_reg;

    albs_store_req_t      store_req;
    logic [COLOR_W-1:0]   rd_word;
    logic                 s_fire;
    logic                 out_load;
    logic [CMP_W-1:0]     out_cmp;
    logic                 out_last;
    logic [SLOT_W-1:0]    tail_inc;
    logic                 color_bit;
    logic [COLOR_W-1:0]   in_color;

    albs_color_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rd_word (rd_word)
    );

    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire   = s_valid && s_ready;
    assign tail_inc = tail_reg + 8'd1;
    assign color_bit = rd_word[bit_ptr_reg];
    assign in_color = {s_data.green, s_data.red, s_data.blue};

    always_comb begin
        state_next   = state_reg;
        sending_next = sending_reg;
        in_tail_next = in_tail_reg;
        led_ptr_next = led_ptr_reg;
        bit_ptr_next = bit_ptr_reg;
        tail_next    = tail_reg;
        store_req    = '0;
        out_load     = 1'b0;
        out_cmp      = '0;
        out_last     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.action)
                        ACT_WRITE_ONE: begin
                            if (!sending_reg && (int'(s_data.led_index) < LED_COUNT)) begin
                                store_req.wr_one  = 1'b1;
                                store_req.addr    = LED_PTR_W'(s_data.led_index);
                                store_req.wr_data = in_color;
                            end
                        end
                        ACT_WRITE_ALL: begin
                            if (!sending_reg) begin
                                store_req.wr_all  = 1'b1;
                                store_req.wr_data = in_color;
                            end
                        end
                        ACT_START: begin
                            if (!sending_reg) begin
                                sending_next = 1'b1;
                                in_tail_next = 1'b0;
                                led_ptr_next = '0;
                                bit_ptr_next = TOP_BIT;
                                tail_next    = '0;
                            end
                        end
                        ACT_TICK: begin
                            if (sending_reg && !in_tail_reg) begin
                                // fetch the current LED, pick the bit next cycle
                                store_req.rd_en = 1'b1;
                                store_req.addr  = led_ptr_reg;
                                state_next      = ST_READ;
                            end else if (sending_reg) begin
                                out_load  = 1'b1;
                                tail_next = tail_inc;
                                if ((tail_inc >= reset_slots_reg) || (tail_inc == '0)) begin
                                    out_last     = 1'b1;
                                    sending_next = 1'b0;
                                    in_tail_next = 1'b0;
                                    tail_next    = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
                out_load   = 1'b1;
                out_cmp    = color_bit ? high_cmp_reg : low_cmp_reg;
                if (bit_ptr_reg == '0) begin
                    bit_ptr_next = TOP_BIT;
                    led_ptr_next = led_ptr_reg + LED_PTR_W'(1);
                    if (led_ptr_reg == LED_PTR_W'(LED_COUNT - 1)) begin
                        led_ptr_next = '0;
                        if (reset_slots_reg == '0) begin
                            out_last     = 1'b1;
                            sending_next = 1'b0;
                        end else begin
                            in_tail_next = 1'b1;
                            tail_next    = '0;
                        end
                    end
                end else begin
                    bit_ptr_next = bit_ptr_reg - BIT_PTR_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sending_reg     <= 1'b0;
            in_tail_reg     <= 1'b0;
            led_ptr_reg     <= '0;
            bit_ptr_reg     <= TOP_BIT;
            tail_reg        <= '0;
            m_valid_reg     <= 1'b0;
            high_cmp_reg    <= HIGH_COMPARE_RST;
            low_cmp_reg     <= LOW_COMPARE_RST;
            reset_slots_reg <= RESET_SLOTS_RST;
        end else begin
            state_reg   <= state_next;
            sending_reg <= sending_next;
            in_tail_reg <= in_tail_next;
            led_ptr_reg <= led_ptr_next;
            bit_ptr_reg <= bit_ptr_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HIGH_COMPARE: high_cmp_reg    <= cfg_wdata;
                    CFG_LOW_COMPARE:  low_cmp_reg     <= cfg_wdata;
                    CFG_RESET_SLOTS:  reset_slots_reg <= cfg_wdata[SLOT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.compare_value <= out_cmp;
            m_data_reg.last_slot     <= out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ALBS_ASSERT(a_read_in_frame, (state_reg == ST_READ) |-> (sending_reg && !in_tail_reg), "store read outside LED data")
    `ALBS_ASSERT(a_bit_ptr_range, bit_ptr_reg <= TOP_BIT, "bit pointer beyond top bit")
    `ALBS_ASSERT(a_last_ends_frame, (out_load && out_last) |=> !sending_reg, "frame runs on after last slot")
    `ALBS_ASSERT(a_no_overwrite, out_load |-> (!m_valid_reg || m_ready), "result register overwritten")
    `ALBS_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (!m_valid_reg && !sending_reg), "reset left frame state")

endmodule

FILE: tb/sv/addressable_led_bit_serializer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// addressable_led_bit_serializer_tb
// Drives colour writes, frame starts and slot ticks into the serializer and
// checks every compare value and last-slot flag against a predictor of the
// colour store and frame sequencer, under changing compare and tail settings.
// ---------------------------------------------------------------------------
module addressable_led_bit_serializer_tb;
    import albs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    class led_frame_scoreboard;
        logic [COLOR_W-1:0]   colors [LED_COUNT];
        bit                   busy;
        bit                   tail_on;
        int unsigned          led_ptr;
        logic [BIT_PTR_W-1:0] bit_ptr;
        logic [SLOT_W-1:0]    tail_cnt;
        logic [CMP_W-1:0]     high_cmp;
        logic [CMP_W-1:0]     low_cmp;
        logic [SLOT_W-1:0]    tail_len;
        albs_out_t            slots_due [$];
        int                   errors;

        function new();
            foreach (colors[i]) colors[i] = '0;
            busy     = 1'b0;
            tail_on  = 1'b0;
            led_ptr  = 0;
            bit_ptr  = TOP_BIT;
            tail_cnt = '0;
            high_cmp = HIGH_COMPARE_RST;
            low_cmp  = LOW_COMPARE_RST;
            tail_len = RESET_SLOTS_RST;
            errors   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_HIGH_COMPARE: high_cmp = val[CMP_W-1:0];
                CFG_LOW_COMPARE:  low_cmp  = val[CMP_W-1:0];
                CFG_RESET_SLOTS:  tail_len = val[SLOT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the frame state for one accepted item; queue the slot it yields
        function void take_item(albs_in_t item);
            logic [COLOR_W-1:0] grb;
            albs_out_t          slot;
            grb  = {item.green, item.red, item.blue};
            slot = '0;
            if (item.action != ACT_TICK) begin
                if (busy) return;
                case (item.action)
                    ACT_WRITE_ONE: begin
                        if (item.led_index < LED_COUNT) colors[item.led_index] = grb;
                    end
                    ACT_WRITE_ALL: begin
                        foreach (colors[i]) colors[i] = grb;
                    end
                    default: begin
                        busy     = 1'b1;
                        tail_on  = 1'b0;
                        led_ptr  = 0;
                        bit_ptr  = TOP_BIT;
                        tail_cnt = '0;
                    end
                endcase
                return;
            end
            if (!busy) return;
            if (!tail_on) begin
                slot.compare_value = colors[led_ptr][bit_ptr] ? high_cmp : low_cmp;
                if (bit_ptr == 0) begin
                    bit_ptr = TOP_BIT;
                    led_ptr++;
                    if (led_ptr >= LED_COUNT) begin
                        led_ptr = 0;
                        if (tail_len == 0) begin
                            slot.last_slot = 1'b1;
                            busy = 1'b0;
                        end else begin
                            tail_on  = 1'b1;
                            tail_cnt = '0;
                        end
                    end
                end else begin
                    bit_ptr--;
                end
            end else begin
                // 8-bit count: a wrap to zero also ends the tail
                tail_cnt++;
                if (tail_cnt >= tail_len || tail_cnt == 0) begin
                    slot.last_slot = 1'b1;
                    busy     = 1'b0;
                    tail_on  = 1'b0;
                    tail_cnt = '0;
                end
            end
            slots_due.push_back(slot);
        endfunction

        function void check_slot(albs_out_t got);
            albs_out_t want;
            if (slots_due.size() == 0) begin
                $display("%0t unexpected slot: expected none, actual compare_value %0d last_slot %0b",
                         $time, got.compare_value, got.last_slot);
                errors++;
                return;
            end
            want = slots_due.pop_front();
            if (got.compare_value !== want.compare_value) begin
                $display("%0t compare_value mismatch: expected %0d actual %0d",
                         $time, want.compare_value, got.compare_value);
                errors++;
            end
            if (got.last_slot !== want.last_slot) begin
                $display("%0t last_slot mismatch: expected %0b actual %0b",
                         $time, want.last_slot, got.last_slot);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    albs_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    albs_out_t             m_data;

    led_frame_scoreboard sb;
    int src_idle_pct = 13;
    int dst_idle_pct = 71;
    int stall_cycles = 0;
    bit s_go = 1'b0;
    bit m_go = 1'b0;

    addressable_led_bit_serializer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Everything settles by the falling edge: what is seen here transfers at the next rise
    always @(negedge aclk) begin
        s_go = s_valid && s_ready;
        m_go = m_valid && m_ready;
        if (aresetn && m_go) sb.check_slot(m_data);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_go || m_go) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic albs_in_t make_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                           logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] r,
                                           logic [CHAN_W-1:0] b);
        albs_in_t item;
        item.action    = act;
        item.led_index = idx;
        item.green     = g;
        item.red       = r;
        item.blue      = b;
        return item;
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    function automatic albs_in_t random_item(logic [ACT_W-1:0] act);
        logic [$bits(albs_in_t)-1:0] raw;
        albs_in_t                    item;
        raw         = $urandom;
        item        = raw;
        item.action = act;
        if (act == ACT_WRITE_ONE || act == ACT_WRITE_ALL) begin
            item.green = pick_channel();
            item.red   = pick_channel();
            item.blue  = pick_channel();
        end
        return item;
    endfunction

    // Called at a rising edge; returns at the rising edge of the transfer
    task automatic send_item(input albs_in_t item);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        sb.take_item(item);
    endtask

    // Hold off the sender until every slot has come back, then let the block settle
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.slots_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_register(idx, val);
    endtask

    task automatic load_config(input logic [CMP_W-1:0] hi, input logic [CMP_W-1:0] lo,
                               input logic [SLOT_W-1:0] slots);
        write_register(CFG_HIGH_COMPARE, CFG_DATA_W'(hi));
        write_register(CFG_LOW_COMPARE, CFG_DATA_W'(lo));
        write_register(CFG_RESET_SLOTS, CFG_DATA_W'(slots));
        write_register(CFG_SPARE, CFG_DATA_W'($urandom_range(1023)));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Colour writes, a start, then ticks until the frame closes. When cut_at is
    // reached in the tail, pause, load hi and lo and shrink the tail to cut_to. Idling follows
    // the LED position: sender light first, then receiver light, then none.
    task automatic run_frame(input int n_writes, input int cut_at,
                             input logic [CMP_W-1:0] hi, input logic [CMP_W-1:0] lo,
                             input logic [SLOT_W-1:0] cut_to);
        bit cut_done;
        cut_done = 1'b0;
        repeat (n_writes) begin
            if ($urandom_range(9) == 0) send_item(random_item(ACT_TICK));
            else send_item(random_item($urandom_range(3) == 0 ? ACT_WRITE_ALL : ACT_WRITE_ONE));
        end
        send_item(random_item(ACT_START));
        while (sb.busy) begin
            if (sb.tail_on || sb.led_ptr >= 2 * LED_COUNT / 3) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end else if (sb.led_ptr < LED_COUNT / 3) begin
                src_idle_pct = 13;
                dst_idle_pct = 71;
            end else begin
                src_idle_pct = 71;
                dst_idle_pct = 13;
            end
            if (!cut_done && sb.tail_on && sb.tail_cnt == cut_at) begin
                wait_drain();
                load_config(hi, lo, cut_to);
                cut_done = 1'b1;
            end
            if ($urandom_range(299) == 0) wait_drain();
            if ($urandom_range(49) == 0) send_item(random_item(ACT_W'($urandom_range(3))));
            else send_item(random_item(ACT_TICK));
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle tick, store extremes, a frame start under reset settings,
        // then writes and a start that the running frame must drop
        send_item(make_item(ACT_TICK, 6'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(ACT_WRITE_ALL, 6'd0, 8'hA5, 8'h5A, 8'h0F));
        send_item(make_item(ACT_WRITE_ONE, 6'd0, 8'hFF, 8'h00, 8'hFF));
        send_item(make_item(ACT_WRITE_ONE, 6'd63, 8'h00, 8'hFF, 8'h00));
        send_item(make_item(ACT_WRITE_ONE, 6'd1, 8'h80, 8'h01, 8'h7F));
        send_item(make_item(ACT_START, 6'd0, 8'h00, 8'h00, 8'h00));
        repeat (14) send_item(make_item(ACT_TICK, 6'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(ACT_START, 6'd63, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(ACT_WRITE_ONE, 6'd2, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(ACT_WRITE_ALL, 6'd63, 8'hFF, 8'hFF, 8'hFF));
        repeat (2) send_item(make_item(ACT_TICK, 6'd63, 8'hFF, 8'hFF, 8'hFF));
        wait_drain();

        // A long tail with extreme compares, then mid-frame swap both compares and cut the tail
        // to nothing after four tail slots so the next slot closes the frame
        load_config(10'd1023, 10'd0, 8'd255);
        run_frame(0, 4, 10'd0, 10'd1023, 8'd0);
        wait_drain();

        // Ticks after the frame has closed yield nothing
        send_item(make_item(ACT_TICK, 6'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(ACT_WRITE_ONE, 6'd5, 8'h12, 8'h34, 8'h56));
        send_item(make_item(ACT_TICK, 6'd5, 8'h00, 8'h00, 8'h00));
        wait_drain();

        if (sb.errors == 0 && sb.slots_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
